// ===== src/nbpe_pkg.sv =====
`default_nettype none
package nbpe_pkg;

  localparam int CUTOFF_W = 39;
  localparam int CLASH_W  = 24;
  localparam int CFG_W    = 39;
  localparam int SUM_W    = 48;
  localparam int FIN_W    = 58;
  localparam int DVD_W    = 42;
  localparam int DVS_W    = 32;
  localparam int OPA_W    = 48;

  localparam logic [1:0] REG_VDW_CUTOFF     = 2'd0;
  localparam logic [1:0] REG_CLASH_LIMIT_SQ = 2'd1;

  localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 39'd6553600;
  localparam logic [CLASH_W-1:0]  CLASH_RESET  = 24'd147456;

  localparam logic signed [39:0] SENTINEL = 40'sd6553600000;
  localparam logic [46:0] MAG_CAP = '1;
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [39:0] OUT_MAX = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] OUT_MIN = {1'b1, {39{1'b0}}};
  // 332.5 doubled, the halving is folded into the product shift
  localparam logic [OPA_W-1:0] COULOMB_X2 = 48'd665;

  localparam logic [3:0] MOP_XX   = 4'd0;
  localparam logic [3:0] MOP_YY   = 4'd1;
  localparam logic [3:0] MOP_ZZ   = 4'd2;
  localparam logic [3:0] MOP_EPS  = 4'd3;
  localparam logic [3:0] MOP_CHRG = 4'd4;
  localparam logic [3:0] MOP_CT1  = 4'd5;
  localparam logic [3:0] MOP_CT2  = 4'd6;
  localparam logic [3:0] MOP_Q2   = 4'd7;
  localparam logic [3:0] MOP_Q3   = 4'd8;
  localparam logic [3:0] MOP_Q6   = 4'd9;
  localparam logic [3:0] MOP_VDW  = 4'd10;
  localparam logic [3:0] MOP_SCL  = 4'd11;
  localparam logic [3:0] MOP_FIN  = 4'd12;

  localparam logic DOP_INV = 1'b0;
  localparam logic DOP_Q   = 1'b1;

  typedef struct packed {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dz;
    logic [15:0]        sigma_a;
    logic [15:0]        sigma_b;
    logic [15:0]        eps_a;
    logic [15:0]        eps_b;
    logic signed [15:0] charge_a;
    logic signed [15:0] charge_b;
    logic [15:0]        pair_scale;
    logic               last_pair;
  } pair_t;

  typedef struct packed {
    logic signed [39:0] total_energy;
    logic               rejected;
  } result_t;

  typedef struct packed {
    logic       load;
    logic       mul_go;
    logic [3:0] mul_op;
    logic       div_go;
    logic       div_op;
    logic       set_rej;
    logic       commit;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic is_clash;
    logic sig_zero;
    logic rejected;
    logic last;
    logic out_free;
  } sts_t;

  function automatic logic [16:0] mag16(input logic signed [15:0] v);
    logic signed [16:0] e;
    e = {v[15], v};
    return e[16] ? 17'(-e) : 17'(e);
  endfunction

  function automatic logic [47:0] mag48(input logic signed [47:0] v);
    return v[47] ? 48'(-v) : 48'(v);
  endfunction

endpackage
`default_nettype wire

// ===== src/nbpe_mul.sv =====
`default_nettype none
module nbpe_mul (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              go,
  input  wire logic [nbpe_pkg::OPA_W-1:0]        a,
  input  wire logic [nbpe_pkg::OPA_W-1:0]        b,
  input  wire logic [4:0]                        sh,
  input  wire logic                              neg,
  input  wire logic                              cap,
  output logic                                   done,
  output logic signed [nbpe_pkg::FIN_W-1:0]      res
);
  import nbpe_pkg::*;

  localparam int HALF = OPA_W / 2;
  localparam int PROD_W = 2 * OPA_W;

  logic [OPA_W-1:0]  ar, br;
  logic [4:0]        shr;
  logic              negr, capr, busy;
  logic [2:0]        step;
  logic [PROD_W-1:0] acc;

  logic [HALF-1:0]   a_part, b_part;
  logic [OPA_W-1:0]  pp;
  logic [PROD_W-1:0] pp_sh, shifted;
  logic [FIN_W-2:0]  mag;

  // four 24x24 partial products, one per cycle
  always_comb begin
    a_part = step[1] ? ar[OPA_W-1:HALF] : ar[HALF-1:0];
    b_part = step[0] ? br[OPA_W-1:HALF] : br[HALF-1:0];
    pp = a_part * b_part;
    case (step)
      3'd0:    pp_sh = PROD_W'(pp);
      3'd3:    pp_sh = PROD_W'(pp) << OPA_W;
      default: pp_sh = PROD_W'(pp) << HALF;
    endcase
    shifted = acc >> shr;
    if (capr && shifted > PROD_W'(MAG_CAP)) mag = (FIN_W-1)'(MAG_CAP);
    else mag = shifted[FIN_W-2:0];
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (go) begin
      ar <= a;
      br <= b;
      shr <= sh;
      negr <= neg;
      capr <= cap;
      acc <= '0;
      step <= 3'd0;
      busy <= 1'b1;
    end else if (busy) begin
      if (step != 3'd4) begin
        acc <= acc + pp_sh;
        step <= step + 3'd1;
      end else begin
        res <= negr ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        done <= 1'b1;
        busy <= 1'b0;
      end
    end
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== src/nbpe_div.sv =====
`default_nettype none
module nbpe_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         go,
  input  wire logic [nbpe_pkg::DVD_W-1:0]   dividend,
  input  wire logic [nbpe_pkg::DVS_W-1:0]   divisor,
  output logic                              done,
  output logic [nbpe_pkg::DVD_W-1:0]        quo
);
  import nbpe_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic [DVS_W-1:0] rem, dvs;
  logic [DVD_W-1:0] dvd;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DVS_W:0]   trial, diff;
  logic             fits;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem, dvd[DVD_W-1]};
    diff = trial - {1'b0, dvs};
    fits = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (go) begin
      rem <= '0;
      dvs <= divisor;
      dvd <= dividend;
      cnt <= CNT_W'(DVD_W - 1);
      busy <= 1'b1;
    end else if (busy) begin
      rem <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo <= {quo[DVD_W-2:0], fits};
      dvd <= dvd << 1;
      cnt <= cnt - CNT_W'(1);
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== src/nbpe_ctrl.sv =====
`default_nettype none
module nbpe_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           pair_valid,
  output logic                pair_stall,
  input  wire nbpe_pkg::sts_t sts,
  output nbpe_pkg::cmd_t      cmd
);
  import nbpe_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_CLASH  = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;
  localparam logic [2:0] ST_FINAL  = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  logic [2:0] state, state_next;
  logic [3:0] op, op_next;
  logic       dop, dop_next;
  logic       launched, launched_next;

  assign pair_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    op_next = op;
    dop_next = dop;
    launched_next = launched;
    cmd = '0;
    cmd.mul_op = op;
    cmd.div_op = dop;
    case (state)
      ST_IDLE: begin
        if (pair_valid) begin
          cmd.load = 1'b1;
          if (sts.rejected) begin
            state_next = ST_FINAL;
          end else begin
            state_next = ST_MUL;
            op_next = MOP_XX;
          end
        end
      end
      ST_MUL: begin
        cmd.mul_go = !launched;
        if (!launched) launched_next = 1'b1;
        if (sts.mul_done) begin
          launched_next = 1'b0;
          state_next = ST_MUL;
          case (op)
            MOP_XX:   op_next = MOP_YY;
            MOP_YY:   op_next = MOP_ZZ;
            MOP_ZZ:   state_next = ST_CLASH;
            MOP_EPS:  op_next = MOP_CHRG;
            MOP_CHRG: op_next = MOP_CT1;
            MOP_CT1:  op_next = MOP_CT2;
            MOP_CT2: begin
              if (sts.sig_zero) begin
                state_next = ST_DECIDE;
              end else begin
                state_next = ST_DIV;
                dop_next = DOP_Q;
              end
            end
            MOP_Q2:   op_next = MOP_Q3;
            MOP_Q3:   op_next = MOP_Q6;
            MOP_Q6:   op_next = MOP_VDW;
            MOP_VDW:  op_next = MOP_SCL;
            MOP_SCL:  state_next = ST_DECIDE;
            MOP_FIN:  state_next = ST_OUT;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        cmd.div_go = !launched;
        if (!launched) launched_next = 1'b1;
        if (sts.div_done) begin
          launched_next = 1'b0;
          state_next = ST_MUL;
          op_next = (dop == DOP_INV) ? MOP_EPS : MOP_Q2;
        end
      end
      ST_CLASH: begin
        if (sts.is_clash) begin
          cmd.set_rej = 1'b1;
          state_next = ST_FINAL;
        end else begin
          state_next = ST_DIV;
          dop_next = DOP_INV;
        end
      end
      ST_DECIDE: begin
        cmd.commit = 1'b1;
        state_next = ST_FINAL;
      end
      ST_FINAL: begin
        if (!sts.last) begin
          state_next = ST_IDLE;
        end else if (sts.rejected) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_MUL;
          op_next = MOP_FIN;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op <= MOP_XX;
      dop <= DOP_INV;
      launched <= 1'b0;
    end else begin
      state <= state_next;
      op <= op_next;
      dop <= dop_next;
      launched <= launched_next;
    end
  end

`ifndef SYNTHESIS
  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    sts.mul_done |-> state == ST_MUL)
    else $error("multiplier finished outside a multiply step");

  a_rejected_skips: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && pair_valid && sts.rejected) |=> state == ST_FINAL)
    else $error("pair of a rejected set was not skipped");
`endif

endmodule
`default_nettype wire

// ===== src/nbpe_dp.sv =====
`default_nettype none
module nbpe_dp (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           wr_en,
  input  wire logic [1:0]                     wr_index,
  input  wire logic [nbpe_pkg::CFG_W-1:0]     wr_data,
  input  wire nbpe_pkg::pair_t                pair,
  output nbpe_pkg::result_t                   result,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  input  wire nbpe_pkg::cmd_t                 cmd,
  output nbpe_pkg::sts_t                      sts
);
  import nbpe_pkg::*;

  logic [CUTOFF_W-1:0] vdw_cutoff;
  logic [CLASH_W-1:0]  clash_limit_sq;

  pair_t                     item;
  logic [31:0]               d;
  logic [32:0]               inv;
  logic [DVD_W-1:0]          q;
  logic [46:0]               q2, q3, q6;
  logic [15:0]               eps;
  logic signed [31:0]        chrg;
  logic signed [SUM_W-1:0]   ct1, cterm, vdw, scaled;
  logic signed [SUM_W-1:0]   charge_sum, vdw_sum;
  logic signed [FIN_W-1:0]   fin;
  logic                      set_rej;

  logic [OPA_W-1:0]          ma, mb;
  logic [4:0]                msh;
  logic                      mneg, mcap, mdone;
  logic signed [FIN_W-1:0]   mres;
  logic [DVD_W-1:0]          dvd, quo;
  logic [DVS_W-1:0]          dvs;
  logic                      ddone;
  logic [16:0]               sig;
  logic [33:0]               sig_sq;
  logic signed [SUM_W-1:0]   diff;
  logic signed [SUM_W:0]     csum, vsum;
  logic signed [FIN_W:0]     total;
  logic signed [39:0]        total_sat;
  logic                      over_cut;

  always_comb begin
    sig = 17'(item.sigma_a) + 17'(item.sigma_b);
    sig_sq = 34'(sig) * 34'(sig);
    diff = $signed({1'b0, q6}) - $signed({1'b0, q3});
    dvs = (d == '0) ? DVS_W'(1) : d;
    dvd = (cmd.div_op == DOP_INV) ? DVD_W'(64'h1_0000_0000) : {sig_sq, 8'd0};
    over_cut = scaled > $signed({9'd0, vdw_cutoff});
    csum = $signed({charge_sum[SUM_W-1], charge_sum}) + $signed({cterm[SUM_W-1], cterm});
    vsum = $signed({vdw_sum[SUM_W-1], vdw_sum}) + $signed({scaled[SUM_W-1], scaled});
    total = $signed({fin[FIN_W-1], fin}) + (FIN_W+1)'(vdw_sum);
    if (total > (FIN_W+1)'(OUT_MAX)) total_sat = OUT_MAX;
    else if (total < (FIN_W+1)'(OUT_MIN)) total_sat = OUT_MIN;
    else total_sat = total[39:0];

    ma = '0;
    mb = '0;
    msh = 5'd0;
    mneg = 1'b0;
    mcap = 1'b1;
    case (cmd.mul_op)
      MOP_XX: begin
        ma = OPA_W'(mag16(item.dx));
        mb = OPA_W'(mag16(item.dx));
      end
      MOP_YY: begin
        ma = OPA_W'(mag16(item.dy));
        mb = OPA_W'(mag16(item.dy));
      end
      MOP_ZZ: begin
        ma = OPA_W'(mag16(item.dz));
        mb = OPA_W'(mag16(item.dz));
      end
      MOP_EPS: begin
        ma = OPA_W'(item.eps_a);
        mb = OPA_W'(item.eps_b);
        msh = 5'd16;
      end
      MOP_CHRG: begin
        ma = OPA_W'(mag16(item.charge_a));
        mb = OPA_W'(mag16(item.charge_b));
        mneg = item.charge_a[15] ^ item.charge_b[15];
      end
      MOP_CT1: begin
        ma = mag48(SUM_W'(chrg));
        mb = OPA_W'(inv);
        msh = 5'd28;
        mneg = chrg[31];
      end
      MOP_CT2: begin
        ma = mag48(ct1);
        mb = OPA_W'(item.pair_scale);
        msh = 5'd15;
        mneg = ct1[SUM_W-1];
      end
      MOP_Q2: begin
        ma = OPA_W'(q);
        mb = OPA_W'(q);
        msh = 5'd16;
      end
      MOP_Q3: begin
        ma = OPA_W'(q2);
        mb = OPA_W'(q);
        msh = 5'd16;
      end
      MOP_Q6: begin
        ma = OPA_W'(q3);
        mb = OPA_W'(q3);
        msh = 5'd16;
      end
      MOP_VDW: begin
        ma = mag48(diff);
        mb = OPA_W'(eps);
        msh = 5'd16;
        mneg = diff[SUM_W-1];
      end
      MOP_SCL: begin
        ma = mag48(vdw);
        mb = OPA_W'(item.pair_scale);
        msh = 5'd13;
        mneg = vdw[SUM_W-1];
      end
      MOP_FIN: begin
        ma = mag48(charge_sum);
        mb = COULOMB_X2;
        msh = 5'd1;
        mneg = charge_sum[SUM_W-1];
        mcap = 1'b0;
      end
      default: ;
    endcase

    sts.mul_done = mdone;
    sts.div_done = ddone;
    sts.is_clash = d < 32'(clash_limit_sq);
    sts.sig_zero = (sig == '0);
    sts.rejected = set_rej;
    sts.last = item.last_pair;
    sts.out_free = !result_valid || !result_stall;
  end

  nbpe_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.mul_go),
    .a    (ma),
    .b    (mb),
    .sh   (msh),
    .neg  (mneg),
    .cap  (mcap),
    .done (mdone),
    .res  (mres)
  );

  nbpe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_go),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (ddone),
    .quo      (quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= pair;
      scaled <= '0;
    end
    if (mdone) begin
      case (cmd.mul_op)
        MOP_XX:   d <= mres[31:0];
        MOP_YY:   d <= d + mres[31:0];
        MOP_ZZ:   d <= d + mres[31:0];
        MOP_EPS:  eps <= mres[15:0];
        MOP_CHRG: chrg <= mres[31:0];
        MOP_CT1:  ct1 <= mres[SUM_W-1:0];
        MOP_CT2:  cterm <= mres[SUM_W-1:0];
        MOP_Q2:   q2 <= mres[46:0];
        MOP_Q3:   q3 <= mres[46:0];
        MOP_Q6:   q6 <= mres[46:0];
        MOP_VDW:  vdw <= mres[SUM_W-1:0];
        MOP_SCL:  scaled <= mres[SUM_W-1:0];
        MOP_FIN:  fin <= mres;
        default: ;
      endcase
    end
    if (ddone) begin
      if (cmd.div_op == DOP_INV) inv <= quo[32:0];
      else q <= quo;
    end
    if (cmd.emit) begin
      result.total_energy <= set_rej ? SENTINEL : total_sat;
      result.rejected <= set_rej;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vdw_cutoff <= CUTOFF_RESET;
      clash_limit_sq <= CLASH_RESET;
      charge_sum <= '0;
      vdw_sum <= '0;
      set_rej <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_VDW_CUTOFF:     vdw_cutoff <= wr_data[CUTOFF_W-1:0];
          REG_CLASH_LIMIT_SQ: clash_limit_sq <= wr_data[CLASH_W-1:0];
          default: ;
        endcase
      end
      if (cmd.set_rej) set_rej <= 1'b1;
      if (cmd.commit) begin
        if (over_cut) begin
          set_rej <= 1'b1;
        end else begin
          if (csum > (SUM_W+1)'(SUM_MAX)) charge_sum <= SUM_MAX;
          else if (csum < (SUM_W+1)'(SUM_MIN)) charge_sum <= SUM_MIN;
          else charge_sum <= csum[SUM_W-1:0];
          if (vsum > (SUM_W+1)'(SUM_MAX)) vdw_sum <= SUM_MAX;
          else if (vsum < (SUM_W+1)'(SUM_MIN)) vdw_sum <= SUM_MIN;
          else vdw_sum <= vsum[SUM_W-1:0];
        end
      end
      if (result_valid && !result_stall) result_valid <= 1'b0;
      if (cmd.emit) begin
        result_valid <= 1'b1;
        charge_sum <= '0;
        vdw_sum <= '0;
        set_rej <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_set_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (charge_sum == '0 && vdw_sum == '0 && !set_rej))
    else $error("set state not cleared after result");

  a_sentinel: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.rejected) |-> result.total_energy == SENTINEL)
    else $error("rejected set without sentinel energy");
`endif

endmodule
`default_nettype wire

// ===== src/nonbond_pair_energy_check.sv =====
// channel   signals                                  moves
// pair      pair_valid, pair_stall, pair             one atom pair request in
// result    result_valid, result_stall, result       set energy after the last pair
// config    wr_en, wr_index, wr_data                 register writes, no read-back
//
// a pair runs two divisions (1/d2 and the sigma ratio, 42 steps each) and twelve
// products on one shared multiplier, each over 24x24 partials; a zero sigma sum skips
// the ratio division and the vdw chain; a clash rejects the set; a pair of an already
// rejected set skips the arithmetic; the last pair adds one product (none if rejected)
// and the output step; reset (rst, synchronous) restores defaults and clears the sums
// a waiting result holds in the output register; the next pair is still taken
`default_nettype none
module nonbond_pair_energy_check (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           pair_valid,
  output logic                                pair_stall,
  input  wire nbpe_pkg::pair_t                pair,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output nbpe_pkg::result_t                   result,
  input  wire logic                           wr_en,
  input  wire logic [1:0]                     wr_index,
  input  wire logic [nbpe_pkg::CFG_W-1:0]     wr_data
);
  import nbpe_pkg::*;

  cmd_t cmd;
  sts_t sts;

  nbpe_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .pair_valid (pair_valid),
    .pair_stall (pair_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  nbpe_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .pair         (pair),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule
`default_nettype wire
